// ===== src/id3pic_pkg.sv =====
// ----------------------------------------------------------------------------
// id3pic_pkg: shared types and constants of the picture frame extractor
// Parse phases, status codes, signature and MIME constants, and the
// bundles that carry one step's results from the parser into the queue.
// ----------------------------------------------------------------------------
package id3pic_pkg;

    // Parse phases
    typedef enum logic [2:0] {
        PH_TAG,
        PH_FHDR,
        PH_SKIP,
        PH_PREFIX,
        PH_SEARCH,
        PH_COPY,
        PH_OTHER,
        PH_DONE
    } phase_t;

    // Final status codes
    localparam logic [2:0] ST_JPEG    = 3'd0;
    localparam logic [2:0] ST_PNG     = 3'd1;
    localparam logic [2:0] ST_OTHER   = 3'd2;
    localparam logic [2:0] ST_NO_ID3  = 3'd3;
    localparam logic [2:0] ST_NO_APIC = 3'd4;
    localparam logic [2:0] ST_NO_SIG  = 3'd5;
    localparam logic [2:0] ST_TRUNC   = 3'd6;

    // Picture types
    localparam logic [1:0] PT_JPEG  = 2'd0;
    localparam logic [1:0] PT_PNG   = 2'd1;
    localparam logic [1:0] PT_OTHER = 2'd2;

    localparam logic [7:0]  SEARCH_WINDOW_RST = 8'd100;
    localparam logic [23:0] TAG_ID            = 24'h494433;   // "ID3"
    localparam logic [31:0] FRAME_ID_APIC     = 32'h41504943; // "APIC"
    localparam logic [31:0] SIG_JPEG          = 32'hFFD8FFE0;
    localparam logic [31:0] SIG_PNG           = 32'h89504E47;
    localparam logic [7:0]  MIME_SLASH        = 8'h2F;
    localparam logic [7:0]  CASE_BIT          = 8'h20;
    localparam logic [0:7][7:0] MIME_JPEG =
        {8'h69, 8'h6D, 8'h61, 8'h67, 8'h65, 8'h2F, 8'h6A, 8'h70};
    localparam logic [0:7][7:0] MIME_PNG =
        {8'h69, 8'h6D, 8'h61, 8'h67, 8'h65, 8'h2F, 8'h70, 8'h6E};

    // Header buffer: byte i of the 10-byte window
    typedef logic [9:0][7:0] hdr_t;

    // Results of one step: nb picture bytes, then an optional status
    typedef struct packed {
        logic [2:0]      nb;
        logic [4:0][7:0] bytes;
        logic            sv;
        logic [2:0]      st;
    } push_t;

    // One queued result: kind 1 is a status with its code in data[2:0]
    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } ent_t;

    // Case-insensitive MIME match on body offsets 1..8, slash exact
    function automatic logic mime_match(input hdr_t h, input logic [0:7][7:0] pat);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < 8; k++) begin
            if (pat[k] == MIME_SLASH) begin
                ok = ok & (h[k + 1] == MIME_SLASH);
            end else begin
                ok = ok & ((h[k + 1] | CASE_BIT) == pat[k]);
            end
        end
        return ok;
    endfunction

endpackage

// ===== src/id3pic_parser.sv =====
// ----------------------------------------------------------------------------
// id3pic_parser: per-byte tag and frame parser
// Walks the ID3 header and frame headers, classifies the APIC body, searches
// the image signature and produces up to five results per accepted byte.
// ----------------------------------------------------------------------------
module id3pic_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic [7:0]           in_byte,
    input  logic                 in_eof,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_wdata,
    output id3pic_pkg::push_t    push
);

    // Tag position is kept in 29 bits: every position at or past 2^28
    // compares the same against the 28-bit tag size.
    localparam logic [28:0] POS_SAT = 29'h1000_0000;

    id3pic_pkg::phase_t phase_reg, phase_next;
    logic [27:0]        tag_size_reg, tag_size_next;
    logic [28:0]        tag_pos_reg, tag_pos_next;
    id3pic_pkg::hdr_t   hdr_reg, hdr_next;
    logic [31:0]        remain_reg, remain_next;
    logic [1:0]         ptype_reg, ptype_next;
    logic [23:0]        sigwin_reg, sigwin_next;
    logic [7:0]         scan_reg, scan_next;
    logic [3:0]         fill_reg, fill_next;
    logic [3:0]         qcnt_reg, qcnt_next;
    logic [7:0]         window_reg;

    id3pic_pkg::hdr_t   hdr_w;
    id3pic_pkg::hdr_t   hdr_q;
    logic [3:0]         fill_inc;
    logic [31:0]        rem_dec;
    logic               rem_dec_zero;
    logic [31:0]        size;
    logic [29:0]        pos_sum;
    logic [31:0]        cand;
    logic [31:0]        want;
    logic               is_jpeg;
    logic               is_png;

    // Queue drain inputs and outputs
    id3pic_pkg::hdr_t   dq;
    logic [3:0]         dcnt;
    logic               d_eof;
    logic               d_zero;
    logic               trunc;
    logic [2:0]         k;
    id3pic_pkg::hdr_t   dq_sh;
    logic [3:0]         qrem;

    // Header buffer with the current byte written at the fill position,
    // and the other-type queue with the current byte appended
    always_comb begin
        hdr_w = hdr_reg;
        hdr_q = hdr_reg;
        for (int i = 0; i < 10; i++) begin
            if (fill_reg == 4'(i)) begin
                hdr_w[i] = in_byte;
            end
            if (qcnt_reg == 4'(i)) begin
                hdr_q[i] = in_byte;
            end
        end
    end

    assign fill_inc     = fill_reg + 4'd1;
    assign rem_dec      = remain_reg - 32'd1;
    assign rem_dec_zero = (remain_reg == 32'd1);
    assign size         = {hdr_w[4], hdr_w[5], hdr_w[6], hdr_w[7]};
    assign pos_sum      = {1'b0, tag_pos_reg} + {2'b00, size[27:0]} + 30'd10;
    assign cand         = {sigwin_reg, in_byte};
    assign want         = (ptype_reg == id3pic_pkg::PT_JPEG) ? id3pic_pkg::SIG_JPEG
                                                             : id3pic_pkg::SIG_PNG;
    assign is_jpeg      = id3pic_pkg::mime_match(hdr_w, id3pic_pkg::MIME_JPEG);
    assign is_png       = id3pic_pkg::mime_match(hdr_w, id3pic_pkg::MIME_PNG);

    // Drain source: fresh prefix at the type decision, else the live queue
    always_comb begin
        if (phase_reg == id3pic_pkg::PH_PREFIX) begin
            dq     = hdr_w;
            dcnt   = fill_inc;
            d_eof  = in_eof;
            d_zero = rem_dec_zero;
        end else if (remain_reg != 32'd0) begin
            dq     = hdr_q;
            dcnt   = qcnt_reg + ((qcnt_reg < 4'd10) ? 4'd1 : 4'd0);
            d_eof  = in_eof;
            d_zero = rem_dec_zero;
        end else begin
            // body over: remaining queue drains, end of file ignored
            dq     = hdr_reg;
            dcnt   = qcnt_reg;
            d_eof  = 1'b0;
            d_zero = 1'b1;
        end
    end

    // Up to five queued bytes per step, four when truncating
    always_comb begin
        trunc = d_eof & ~d_zero;
        if (trunc) begin
            k = (dcnt < 4'd4) ? dcnt[2:0] : 3'd4;
        end else begin
            k = (dcnt < 4'd5) ? dcnt[2:0] : 3'd5;
        end
        dq_sh = dq >> {k, 3'b000};
        qrem  = dcnt - {1'b0, k};
    end

    // Next state and results
    always_comb begin
        phase_next    = phase_reg;
        tag_size_next = tag_size_reg;
        tag_pos_next  = tag_pos_reg;
        hdr_next      = hdr_reg;
        remain_next   = remain_reg;
        ptype_next    = ptype_reg;
        sigwin_next   = sigwin_reg;
        scan_next     = scan_reg;
        fill_next     = fill_reg;
        qcnt_next     = qcnt_reg;
        push          = '0;

        unique case (phase_reg)
            id3pic_pkg::PH_TAG: begin
                hdr_next  = hdr_w;
                fill_next = fill_inc;
                if (fill_reg == 4'd9) begin
                    fill_next = 4'd0;
                    if ({hdr_w[0], hdr_w[1], hdr_w[2]} != id3pic_pkg::TAG_ID) begin
                        push.sv    = 1'b1;
                        push.st    = id3pic_pkg::ST_NO_ID3;
                        phase_next = id3pic_pkg::PH_DONE;
                    end else begin
                        tag_size_next = {hdr_w[6][6:0], hdr_w[7][6:0],
                                         hdr_w[8][6:0], hdr_w[9][6:0]};
                        phase_next    = id3pic_pkg::PH_FHDR;
                    end
                end
            end

            id3pic_pkg::PH_FHDR: begin
                hdr_next  = hdr_w;
                fill_next = fill_inc;
                if (fill_reg == 4'd9) begin
                    fill_next = 4'd0;
                    if ({hdr_w[0], hdr_w[1], hdr_w[2], hdr_w[3]} ==
                        id3pic_pkg::FRAME_ID_APIC) begin
                        remain_next = size;
                        hdr_next    = '0;
                        phase_next  = id3pic_pkg::PH_PREFIX;
                        if (size == 32'd0) begin
                            // empty body: all-zero prefix is other type
                            ptype_next = id3pic_pkg::PT_OTHER;
                            push.sv    = 1'b1;
                            push.st    = id3pic_pkg::ST_OTHER;
                            phase_next = id3pic_pkg::PH_DONE;
                        end
                    end else if (tag_pos_reg < {1'b0, tag_size_reg}) begin
                        if ((|size[31:28]) || (|pos_sum[29:28])) begin
                            tag_pos_next = POS_SAT;
                        end else begin
                            tag_pos_next = pos_sum[28:0];
                        end
                        remain_next = size;
                        phase_next  = (size != 32'd0) ? id3pic_pkg::PH_SKIP
                                                      : id3pic_pkg::PH_FHDR;
                    end else begin
                        push.sv    = 1'b1;
                        push.st    = id3pic_pkg::ST_NO_APIC;
                        phase_next = id3pic_pkg::PH_DONE;
                    end
                end
            end

            id3pic_pkg::PH_SKIP: begin
                remain_next = rem_dec;
                if (rem_dec_zero) begin
                    fill_next  = 4'd0;
                    phase_next = id3pic_pkg::PH_FHDR;
                end
            end

            id3pic_pkg::PH_PREFIX: begin
                hdr_next    = hdr_w;
                fill_next   = fill_inc;
                remain_next = rem_dec;
                if (fill_reg == 4'd9 || rem_dec_zero) begin
                    if (is_jpeg || is_png) begin
                        ptype_next = is_jpeg ? id3pic_pkg::PT_JPEG : id3pic_pkg::PT_PNG;
                        if (rem_dec_zero) begin
                            push.sv    = 1'b1;
                            push.st    = id3pic_pkg::ST_NO_SIG;
                            phase_next = id3pic_pkg::PH_DONE;
                        end else begin
                            phase_next  = id3pic_pkg::PH_SEARCH;
                            fill_next   = 4'd0;
                            scan_next   = 8'd0;
                            sigwin_next = '0;
                        end
                    end else begin
                        ptype_next = id3pic_pkg::PT_OTHER;
                        push.nb    = k;
                        push.bytes = dq[4:0];
                        hdr_next   = dq_sh;
                        qcnt_next  = qrem;
                        phase_next = id3pic_pkg::PH_OTHER;
                        if (trunc) begin
                            qcnt_next  = 4'd0;
                            push.sv    = 1'b1;
                            push.st    = id3pic_pkg::ST_TRUNC;
                            phase_next = id3pic_pkg::PH_DONE;
                        end else if (d_zero && qrem == 4'd0 && k != 3'd5) begin
                            push.sv    = 1'b1;
                            push.st    = id3pic_pkg::ST_OTHER;
                            phase_next = id3pic_pkg::PH_DONE;
                        end
                    end
                end
            end

            id3pic_pkg::PH_SEARCH: begin
                remain_next = rem_dec;
                if (fill_reg < 4'd3) begin
                    // priming the three-byte window
                    fill_next   = fill_inc;
                    sigwin_next = cand[23:0];
                    if (rem_dec_zero) begin
                        push.sv    = 1'b1;
                        push.st    = id3pic_pkg::ST_NO_SIG;
                        phase_next = id3pic_pkg::PH_DONE;
                    end
                end else if (cand == want) begin
                    push.nb    = 3'd4;
                    push.bytes = {8'h00, cand[7:0], cand[15:8], cand[23:16], cand[31:24]};
                    phase_next = id3pic_pkg::PH_COPY;
                    if (rem_dec_zero) begin
                        push.sv    = 1'b1;
                        push.st    = {1'b0, ptype_reg};
                        phase_next = id3pic_pkg::PH_DONE;
                    end
                end else if (scan_reg >= window_reg || rem_dec_zero) begin
                    push.sv    = 1'b1;
                    push.st    = id3pic_pkg::ST_NO_SIG;
                    phase_next = id3pic_pkg::PH_DONE;
                end else begin
                    scan_next   = scan_reg + 8'd1;
                    sigwin_next = cand[23:0];
                end
            end

            id3pic_pkg::PH_COPY: begin
                push.nb       = 3'd1;
                push.bytes[0] = in_byte;
                remain_next   = rem_dec;
                if (rem_dec_zero) begin
                    push.sv    = 1'b1;
                    push.st    = {1'b0, ptype_reg};
                    phase_next = id3pic_pkg::PH_DONE;
                end
            end

            id3pic_pkg::PH_OTHER: begin
                if (remain_reg != 32'd0) begin
                    remain_next = rem_dec;
                end
                push.nb    = k;
                push.bytes = dq[4:0];
                hdr_next   = dq_sh;
                qcnt_next  = qrem;
                if (trunc) begin
                    qcnt_next  = 4'd0;
                    push.sv    = 1'b1;
                    push.st    = id3pic_pkg::ST_TRUNC;
                    phase_next = id3pic_pkg::PH_DONE;
                end else if (d_zero && qrem == 4'd0 && k != 3'd5) begin
                    push.sv    = 1'b1;
                    push.st    = id3pic_pkg::ST_OTHER;
                    phase_next = id3pic_pkg::PH_DONE;
                end
            end

            id3pic_pkg::PH_DONE: begin
                // finished: inputs are dropped until reset
            end
        endcase

        // End of file before the final status
        if (in_eof && phase_next != id3pic_pkg::PH_DONE &&
            phase_next != id3pic_pkg::PH_OTHER) begin
            push.sv    = 1'b1;
            push.st    = id3pic_pkg::ST_TRUNC;
            phase_next = id3pic_pkg::PH_DONE;
        end
    end

    // Parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= id3pic_pkg::PH_TAG;
            tag_size_reg <= '0;
            tag_pos_reg  <= '0;
            hdr_reg      <= '0;
            remain_reg   <= '0;
            ptype_reg    <= id3pic_pkg::PT_JPEG;
            sigwin_reg   <= '0;
            scan_reg     <= '0;
            fill_reg     <= '0;
            qcnt_reg     <= '0;
        end else if (in_fire) begin
            phase_reg    <= phase_next;
            tag_size_reg <= tag_size_next;
            tag_pos_reg  <= tag_pos_next;
            hdr_reg      <= hdr_next;
            remain_reg   <= remain_next;
            ptype_reg    <= ptype_next;
            sigwin_reg   <= sigwin_next;
            scan_reg     <= scan_next;
            fill_reg     <= fill_next;
            qcnt_reg     <= qcnt_next;
        end
    end

    // Search window register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= id3pic_pkg::SEARCH_WINDOW_RST;
        end else if (cfg_we) begin
            window_reg <= cfg_wdata;
        end
    end

endmodule

// ===== src/id3pic_out_queue.sv =====
// ----------------------------------------------------------------------------
// id3pic_out_queue: result queue
// Shift queue that takes up to five results of one step at once and hands
// them out one per request on the result channel.
// ----------------------------------------------------------------------------
module id3pic_out_queue #(
    parameter int DEPTH = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_en,
    input  id3pic_pkg::push_t    push,
    output logic                 room,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_result_kind,
    output logic [7:0]           m_image_byte,
    output logic [2:0]           m_status_code,
    output logic                 m_last_result
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 5);

    logic [CW-1:0]      cnt_reg, cnt_next;
    id3pic_pkg::ent_t   ent_reg  [DEPTH];
    id3pic_pkg::ent_t   ent_next [DEPTH];
    id3pic_pkg::ent_t   shifted  [DEPTH];
    id3pic_pkg::ent_t   items    [5];
    logic               pop;
    logic [CW-1:0]      cnt_p;
    logic [CW-1:0]      n_push;
    logic [CW-1:0]      off;

    assign m_valid = (cnt_reg != '0);
    assign pop     = m_valid & m_ready;
    assign room    = (cnt_reg <= ROOM_MAX);
    assign cnt_p   = cnt_reg - CW'(pop);
    assign n_push  = push_en ? (CW'(push.nb) + CW'(push.sv)) : '0;

    // Step results in order: picture bytes, then the status
    always_comb begin
        for (int j = 0; j < 5; j++) begin
            if (3'(j) < push.nb) begin
                items[j] = '{kind: 1'b0, data: push.bytes[j]};
            end else begin
                items[j] = '{kind: 1'b1, data: {5'b00000, push.st}};
            end
        end
    end

    // Pop shifts toward the head, new results land after the survivors
    always_comb begin
        for (int i = 0; i < DEPTH - 1; i++) begin
            shifted[i] = ent_reg[i + 1];
        end
        shifted[DEPTH-1] = ent_reg[DEPTH-1];
        for (int i = 0; i < DEPTH; i++) begin
            ent_next[i] = pop ? shifted[i] : ent_reg[i];
            off         = CW'(i) - cnt_p;
            if (CW'(i) >= cnt_p && off < n_push) begin
                ent_next[i] = items[off[2:0]];
            end
        end
        cnt_next = cnt_p + n_push;
    end

    // Fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Entries
    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            ent_reg[i] <= ent_next[i];
        end
    end

    // Head entry to result fields
    assign m_result_kind = ent_reg[0].kind;
    assign m_image_byte  = ent_reg[0].kind ? 8'h00 : ent_reg[0].data;
    assign m_status_code = ent_reg[0].kind ? ent_reg[0].data[2:0] : 3'd0;
    assign m_last_result = ent_reg[0].kind;

endmodule

// ===== src/id3v2_picture_frame_extractor.sv =====
// ----------------------------------------------------------------------------
// id3v2_picture_frame_extractor: APIC picture extraction from an MP3 stream
// Checks the ID3 tag header, walks the frames to APIC, classifies the MIME
// type and streams the picture bytes from the signature, then one status.
// ----------------------------------------------------------------------------
//   channel   ports                     moves
//   -------   -----------------------   ---------------------------------
//   s_        valid/ready               one file byte per request
//   m_        valid/ready               one picture byte or the status
//   cfg_      cfg_we, cfg_wdata         search window, write only
//
// One byte is taken per cycle while the result queue holds at most
// OUT_DEPTH-5 entries; results leave at one per cycle while m_ready is
// high. A signature match pushes four or five results at once and can
// hold s_ready low. Reset is synchronous; after reset the block takes
// bytes at once. Both sides may stall freely; the queue keeps the order.
// ----------------------------------------------------------------------------
module id3v2_picture_frame_extractor #(
    parameter int OUT_DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_file,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [7:0]  m_image_byte,
    output logic [2:0]  m_status_code,
    output logic        m_last_result,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    id3pic_pkg::push_t push;
    logic              in_fire;

    assign in_fire = s_valid & s_ready;

    // Parser
    id3pic_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_byte   (s_data_byte),
        .in_eof    (s_end_of_file),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push)
    );

    // Result queue
    id3pic_out_queue #(
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push_en       (in_fire),
        .push          (push),
        .room          (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_image_byte  (m_image_byte),
        .m_status_code (m_status_code),
        .m_last_result (m_last_result)
    );

endmodule

// ===== src/id3pic_checker.sv =====
// ----------------------------------------------------------------------------
// id3pic_checker: port-level checks for the picture frame extractor
// Watches both channels for payload hold, field consistency and
// end-of-stream rules.
// ----------------------------------------------------------------------------
module id3pic_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_file,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_result_kind,
    input  logic [7:0]  m_image_byte,
    input  logic [2:0]  m_status_code,
    input  logic        m_last_result
);

    // A waiting request holds its payload until taken
    a_req_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data_byte) &&
        $stable(s_end_of_file))
        else $error("request changed while stalled");

    // A pending result holds until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind) &&
        $stable(m_image_byte) && $stable(m_status_code) && $stable(m_last_result))
        else $error("result changed while stalled");

    // A status result is the last one, carries no picture byte and has a code other than 7
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind |-> m_last_result && m_image_byte == 8'h00 &&
        m_status_code != 3'd7)
        else $error("malformed status result");

    // A picture byte carries no status
    a_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_result_kind |-> !m_last_result && m_status_code == 3'd0)
        else $error("malformed picture byte result");

    // Nothing follows the final status
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_result |=> !m_valid)
        else $error("result after final status");

endmodule

bind id3v2_picture_frame_extractor id3pic_checker u_checker (.*);
